// ===== hw/rtl/jsu_pkg.sv =====
// jsu_pkg: shared types and constants for the JSON string unescape block.
// Holds the decoder phase enum, input kind codes, error codes and the job
// record that moves from the front decoder through the queue to the emitter.
package jsu_pkg;

    // Input kind codes
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_NEXT  = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_CONTROL   = 3'd1;
    localparam logic [2:0] ERR_ESCAPE    = 3'd2;
    localparam logic [2:0] ERR_HEX       = 3'd3;
    localparam logic [2:0] ERR_SURROGATE = 3'd4;
    localparam logic [2:0] ERR_UNTERM    = 3'd5;

    // Character codes
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_BS_OUT    = 8'h08;
    localparam logic [7:0] CH_FF_OUT    = 8'h0C;
    localparam logic [7:0] CH_LF_OUT    = 8'h0A;
    localparam logic [7:0] CH_CR_OUT    = 8'h0D;
    localparam logic [7:0] CH_TAB_OUT   = 8'h09;

    // Surrogate ranges
    localparam logic [15:0] HI_SURR_LO = 16'hD800;
    localparam logic [15:0] HI_SURR_HI = 16'hDBFF;
    localparam logic [15:0] LO_SURR_LO = 16'hDC00;
    localparam logic [15:0] LO_SURR_HI = 16'hDFFF;

    // Decoder phase
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BODY,
        PH_ESC,
        PH_HEX1,
        PH_WANT_BS,
        PH_WANT_U,
        PH_HEX2,
        PH_DONE
    } phase_t;

    // One decoded input: up to four results, emitted in order
    typedef struct packed {
        logic [1:0]      last_idx;   // index of the final result
        logic [3:0][7:0] bytes;      // decoded bytes, entry 0 first
        logic            has_byte;
        logic            closed;
        logic [2:0]      err;
    } job_t;

endpackage

// ===== hw/rtl/jsu_front.sv =====
// jsu_front: accepts text bytes, runs the escape/hex/surrogate state machine
// and turns each input into one job record (or none) for the queue.
// Depends on jsu_pkg.
module jsu_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [1:0]      kind,
    input  logic [7:0]      in_byte,
    input  logic            q_full,
    output logic            push,
    output jsu_pkg::job_t   push_job
);

    jsu_pkg::phase_t phase_reg, phase_next, ph;
    logic [15:0]     acc_reg, acc_next, acc_shift;
    logic [9:0]      hs_reg, hs_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic [4:0]      hexv;
    logic [10:0]     pair_hi;
    logic            emit;
    logic            take;

    // Hex digit value; bit 4 flags a non-hex byte
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c inside {[8'h30:8'h39]})
            v = {1'b0, c[3:0]};
        else if (c inside {[8'h61:8'h66], [8'h41:8'h46]})
            v = {1'b0, c[3:0] + 4'd9};
        return v;
    endfunction

    // UTF-8 encoding of a code point as a job with 1 to 4 bytes
    function automatic jsu_pkg::job_t encode(input logic [20:0] cp);
        jsu_pkg::job_t j;
        j = '0;
        j.has_byte = 1'b1;
        if (cp < 21'h80) begin
            j.last_idx = 2'd0;
            j.bytes[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            j.last_idx = 2'd1;
            j.bytes[0] = {3'b110, cp[10:6]};
            j.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            j.last_idx = 2'd2;
            j.bytes[0] = {4'b1110, cp[15:12]};
            j.bytes[1] = {2'b10, cp[11:6]};
            j.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            j.last_idx = 2'd3;
            j.bytes[0] = {5'b11110, cp[20:18]};
            j.bytes[1] = {2'b10, cp[17:12]};
            j.bytes[2] = {2'b10, cp[11:6]};
            j.bytes[3] = {2'b10, cp[5:0]};
        end
        return j;
    endfunction

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;
    assign push     = take && emit;

    // Decode one byte
    always_comb
    begin
        ph         = (kind == jsu_pkg::KIND_START) ? jsu_pkg::PH_BODY : phase_reg;
        phase_next = ph;
        acc_next   = acc_reg;
        hs_next    = hs_reg;
        cnt_next   = cnt_reg;
        push_job   = '0;
        emit       = 1'b0;
        hexv       = hex_value(in_byte);
        acc_shift  = {acc_reg[11:0], hexv[3:0]};
        pair_hi    = {1'b0, hs_reg} + 11'h040;

        if (kind == jsu_pkg::KIND_START || kind == jsu_pkg::KIND_NEXT) begin
            case (ph)
                jsu_pkg::PH_BODY:
                begin
                    if (in_byte == jsu_pkg::CH_QUOTE) begin
                        emit            = 1'b1;
                        push_job.closed = 1'b1;
                        phase_next      = jsu_pkg::PH_DONE;
                    end else if (in_byte == jsu_pkg::CH_BACKSLASH) begin
                        phase_next = jsu_pkg::PH_ESC;
                    end else if (in_byte < jsu_pkg::CH_SPACE) begin
                        emit         = 1'b1;
                        push_job.err = jsu_pkg::ERR_CONTROL;
                        phase_next   = jsu_pkg::PH_DONE;
                    end else begin
                        emit              = 1'b1;
                        push_job.has_byte = 1'b1;
                        push_job.bytes[0] = in_byte;
                    end
                end
                jsu_pkg::PH_ESC:
                begin
                    phase_next        = jsu_pkg::PH_BODY;
                    emit              = 1'b1;
                    push_job.has_byte = 1'b1;
                    case (in_byte)
                        jsu_pkg::CH_QUOTE, jsu_pkg::CH_BACKSLASH, jsu_pkg::CH_SLASH:
                            push_job.bytes[0] = in_byte;
                        jsu_pkg::CH_B: push_job.bytes[0] = jsu_pkg::CH_BS_OUT;
                        jsu_pkg::CH_F: push_job.bytes[0] = jsu_pkg::CH_FF_OUT;
                        jsu_pkg::CH_N: push_job.bytes[0] = jsu_pkg::CH_LF_OUT;
                        jsu_pkg::CH_R: push_job.bytes[0] = jsu_pkg::CH_CR_OUT;
                        jsu_pkg::CH_T: push_job.bytes[0] = jsu_pkg::CH_TAB_OUT;
                        jsu_pkg::CH_U:
                        begin
                            emit              = 1'b0;
                            push_job.has_byte = 1'b0;
                            phase_next        = jsu_pkg::PH_HEX1;
                            acc_next          = '0;
                            cnt_next          = '0;
                        end
                        default:
                        begin
                            push_job.has_byte = 1'b0;
                            push_job.err      = jsu_pkg::ERR_ESCAPE;
                            phase_next        = jsu_pkg::PH_DONE;
                        end
                    endcase
                end
                jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2:
                begin
                    if (hexv[4]) begin
                        emit         = 1'b1;
                        push_job.err = jsu_pkg::ERR_HEX;
                        phase_next   = jsu_pkg::PH_DONE;
                    end else begin
                        acc_next = acc_shift;
                        if (cnt_reg != 2'd3) begin
                            cnt_next = cnt_reg + 2'd1;
                        end else begin
                            cnt_next = '0;
                            if (ph == jsu_pkg::PH_HEX1) begin
                                if (acc_shift inside
                                    {[jsu_pkg::HI_SURR_LO:jsu_pkg::HI_SURR_HI]}) begin
                                    hs_next    = acc_shift[9:0];
                                    phase_next = jsu_pkg::PH_WANT_BS;
                                end else if (acc_shift inside
                                    {[jsu_pkg::LO_SURR_LO:jsu_pkg::LO_SURR_HI]}) begin
                                    emit         = 1'b1;
                                    push_job.err = jsu_pkg::ERR_SURROGATE;
                                    phase_next   = jsu_pkg::PH_DONE;
                                end else begin
                                    emit       = 1'b1;
                                    push_job   = encode({5'd0, acc_shift});
                                    phase_next = jsu_pkg::PH_BODY;
                                end
                            end else begin
                                if (acc_shift inside
                                    {[jsu_pkg::LO_SURR_LO:jsu_pkg::LO_SURR_HI]}) begin
                                    emit       = 1'b1;
                                    push_job   = encode({pair_hi, acc_shift[9:0]});
                                    phase_next = jsu_pkg::PH_BODY;
                                end else begin
                                    emit         = 1'b1;
                                    push_job.err = jsu_pkg::ERR_SURROGATE;
                                    phase_next   = jsu_pkg::PH_DONE;
                                end
                            end
                        end
                    end
                end
                jsu_pkg::PH_WANT_BS:
                begin
                    if (in_byte == jsu_pkg::CH_BACKSLASH) begin
                        phase_next = jsu_pkg::PH_WANT_U;
                    end else begin
                        emit         = 1'b1;
                        push_job.err = jsu_pkg::ERR_SURROGATE;
                        phase_next   = jsu_pkg::PH_DONE;
                    end
                end
                jsu_pkg::PH_WANT_U:
                begin
                    if (in_byte == jsu_pkg::CH_U) begin
                        phase_next = jsu_pkg::PH_HEX2;
                        acc_next   = '0;
                        cnt_next   = '0;
                    end else begin
                        emit         = 1'b1;
                        push_job.err = jsu_pkg::ERR_SURROGATE;
                        phase_next   = jsu_pkg::PH_DONE;
                    end
                end
                default:
                begin
                end
            endcase
        end else if (kind == jsu_pkg::KIND_END) begin
            if (phase_reg inside {[jsu_pkg::PH_BODY:jsu_pkg::PH_HEX2]}) begin
                emit         = 1'b1;
                push_job.err = jsu_pkg::ERR_UNTERM;
                phase_next   = jsu_pkg::PH_DONE;
            end
        end
    end

    // Advance decoder state on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= jsu_pkg::PH_IDLE;
            acc_reg   <= '0;
            hs_reg    <= '0;
            cnt_reg   <= '0;
        end else if (take) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            hs_reg    <= hs_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== hw/rtl/jsu_queue.sv =====
// jsu_queue: small flop-based FIFO of job records between decoder and emitter.
// Depends on jsu_pkg for the job record type.
module jsu_queue #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  jsu_pkg::job_t   push_job,
    output logic            full,
    input  logic            pop,
    output jsu_pkg::job_t   head,
    output logic            empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jsu_pkg::job_t  mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Store pushed job
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== hw/rtl/jsu_back.sv =====
// jsu_back: walks the job at the queue head and presents its results one per
// transfer, flagging the final one. Depends on jsu_pkg.
module jsu_back (
    input  logic            clk,
    input  logic            rst_n,
    input  jsu_pkg::job_t   head,
    input  logic            empty,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_byte,
    output logic            byte_valid,
    output logic            closed,
    output logic [2:0]      error_code,
    output logic            last
);

    logic [1:0] idx_reg;
    logic       is_last;

    assign out_valid  = !empty;
    assign is_last    = (idx_reg == head.last_idx);
    assign out_byte   = head.has_byte ? head.bytes[idx_reg] : 8'd0;
    assign byte_valid = head.has_byte;
    assign closed     = head.closed;
    assign error_code = head.err;
    assign last       = is_last;
    assign pop        = out_valid && out_ready && is_last;

    // Step through results of the head job
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (out_valid && out_ready)
            idx_reg <= is_last ? 2'd0 : idx_reg + 2'd1;
    end

endmodule

// ===== hw/rtl/json_string_unescape_utf8.sv =====
// json_string_unescape_utf8: top level of the streaming JSON string decoder.
// Instantiates jsu_front, jsu_queue and jsu_back; depends on jsu_pkg.
//
//   Channel  Handshake             Payload
//   input    in_valid / in_ready   kind, in_byte
//   output   out_valid / out_ready out_byte, byte_valid, closed, error_code, last
//
// One input byte is taken per cycle while the job queue has room.
// Results leave one per cycle while out_ready is high; a \u escape gives one result
// per UTF-8 byte it decodes to, 1 to 3 bytes, or 4 for a surrogate pair.
// The first result of an input is presented once its job, registered in the queue, reaches the queue head.
// Reset is asynchronous, active low, and empties the queue and sets idle.
// Output stalls fill the QUEUE_DEPTH-entry queue, then drop in_ready.
module json_string_unescape_utf8 #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        closed,
    output logic [2:0]  error_code,
    output logic        last
);

    jsu_pkg::job_t push_job, head;
    logic          push, pop, q_full, q_empty;

    jsu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .in_byte  (in_byte),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty)
    );

    jsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (q_empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .closed     (closed),
        .error_code (error_code),
        .last       (last)
    );

endmodule

// ===== hw/rtl/jsu_checker.sv =====
// jsu_checker: port-level checks on the JSON string decoder outputs.
// Bound to json_string_unescape_utf8; depends on jsu_pkg error codes.
module jsu_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  out_byte,
    input  logic        byte_valid,
    input  logic        closed,
    input  logic [2:0]  error_code,
    input  logic        last
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last)
            && $stable(closed) && $stable(error_code))
        else $error("stalled result changed");

    // Close and error results end an input and carry no byte
    a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (closed || error_code != jsu_pkg::ERR_NONE) |->
            last && !byte_valid && out_byte == 8'd0)
        else $error("terminal result malformed");

    // A result is a byte, a close or an error, never two of them
    a_one_role: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $countones({byte_valid, closed, error_code != jsu_pkg::ERR_NONE}) == 1)
        else $error("result has no single role");

    // Continuation bytes follow a non-final multi-byte lead
    a_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && byte_valid && !last |=>
            out_valid && byte_valid && out_byte[7:6] == 2'b10)
        else $error("expected UTF-8 continuation byte");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (.*);
